// File: rtl/mips_subset_instruction_execute_assert.svh
// assertion macros used by the port-level checker
`ifndef MIPS_SUBSET_INSTRUCTION_EXECUTE_ASSERT_SVH
`define MIPS_SUBSET_INSTRUCTION_EXECUTE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define MSIE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define MSIE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/msie_pkg.sv
// ---------------------------------------------------------------------------
// msie_pkg
// shared widths, operation codes and register file port types
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package msie_pkg;

    localparam int XLEN        = 32;
    localparam int PC_W        = 20;
    localparam int RIDX_W      = 5;
    localparam int NREGS       = 32;
    localparam int MADDR_W     = 10;
    localparam int FUNC_W      = 4;
    localparam int S_TDATA_W   = 80;
    localparam int S_TUSER_W   = 4;
    localparam int M_TDATA_W   = 64;
    localparam int M_TUSER_W   = 1;

    localparam logic [FUNC_W-1:0] FN_ADD  = 4'd0;
    localparam logic [FUNC_W-1:0] FN_SUB  = 4'd1;
    localparam logic [FUNC_W-1:0] FN_MUL  = 4'd2;
    localparam logic [FUNC_W-1:0] FN_SLT  = 4'd3;
    localparam logic [FUNC_W-1:0] FN_ADDI = 4'd4;
    localparam logic [FUNC_W-1:0] FN_BEQ  = 4'd5;
    localparam logic [FUNC_W-1:0] FN_BNE  = 4'd6;
    localparam logic [FUNC_W-1:0] FN_J    = 4'd7;
    localparam logic [FUNC_W-1:0] FN_LW   = 4'd8;
    localparam logic [FUNC_W-1:0] FN_SW   = 4'd9;

    localparam logic ST_OK      = 1'b0;
    localparam logic ST_UNKNOWN = 1'b1;

    typedef struct packed {
        logic              en;
        logic [RIDX_W-1:0] addr0;
        logic [RIDX_W-1:0] addr1;
    } t_rf_rd;

    typedef struct packed {
        logic              en;
        logic [RIDX_W-1:0] addr;
        logic [XLEN-1:0]   data;
    } t_rf_wr;

endpackage

// File: rtl/msie_regfile.sv
// ---------------------------------------------------------------------------
// msie_regfile
// 32 x 32 register file, two registered read ports, one write port,
// per-entry valid bits so that unwritten entries and register zero read zero
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module msie_regfile (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  msie_pkg::t_rf_rd            i_rd,
    input  msie_pkg::t_rf_wr            i_wr,
    output logic [msie_pkg::XLEN-1:0]   o_data0,
    output logic [msie_pkg::XLEN-1:0]   o_data1
);
    import msie_pkg::*;

    logic [XLEN-1:0]  r_mem [NREGS];
    logic [NREGS-1:0] r_vld;
    logic [XLEN-1:0]  r_q0;
    logic [XLEN-1:0]  r_q1;
    logic             r_ok0;
    logic             r_ok1;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_q0 <= r_mem[i_rd.addr0];
            r_q1 <= r_mem[i_rd.addr1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ok0 <= 1'b0;
            r_ok1 <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_ok0 <= r_vld[i_rd.addr0] && (i_rd.addr0 != '0);
                r_ok1 <= r_vld[i_rd.addr1] && (i_rd.addr1 != '0);
            end
        end
    end

    assign o_data0 = r_ok0 ? r_q0 : '0;
    assign o_data1 = r_ok1 ? r_q1 : '0;

endmodule

// File: rtl/msie_dmem.sv
// ---------------------------------------------------------------------------
// msie_dmem
// word data memory, one registered read port and one write port, with a
// zero-fill sweep over every word after reset
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module msie_dmem #(
    parameter  int DATA_WORDS = 1024,
    localparam int AW         = $clog2(DATA_WORDS)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [msie_pkg::XLEN-1:0]   i_wr_data,
    output logic [msie_pkg::XLEN-1:0]   o_rd_data,
    output logic                        o_clr_done
);
    import msie_pkg::*;

    logic [XLEN-1:0] r_mem [DATA_WORDS];
    logic [XLEN-1:0] r_q;
    logic            r_clr_busy;
    logic [AW-1:0]   r_clr_cnt;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [XLEN-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_cnt == AW'(DATA_WORDS - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
        end
    end

    assign wr_en   = r_clr_busy || i_wr_en;
    assign wr_addr = r_clr_busy ? r_clr_cnt : i_wr_addr;
    assign wr_data = r_clr_busy ? '0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_q;
    assign o_clr_done = !r_clr_busy;

endmodule

// File: rtl/mips_subset_instruction_execute.sv
// ---------------------------------------------------------------------------
// mips_subset_instruction_execute
// executes one decoded instruction per beat against a register file, a
// program counter and a word data memory; one result beat per instruction
// ---------------------------------------------------------------------------
//  channel   dir  tdata / tuser
//  s_axis    in   instruction fields / func
//  m_axis    out  next pc and register write / status
//
//  one instruction per cycle sustained while m_axis accepts; the result beat is
//  registered by the operand read, then by the output register
//  after reset the data memory is zero-filled over every word, s tready low
//  a stalled m_axis holds the output register; s tready drops only when the
//  execute stage and the output register are both occupied
//  reads forward from the register and memory write of the instruction ahead
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mips_subset_instruction_execute #(
    parameter int DATA_WORDS   = 1024,
    parameter int PROGRAM_SIZE = 1048576
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // first_reg, second_reg, third_reg, use_immediate, immediate,
    // target_pc, mem_addr, zero pad
    input  logic [msie_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // func
    input  logic [msie_pkg::S_TUSER_W-1:0]   i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // next_pc, reg_written, written_reg, written_value, zero pad
    output logic [msie_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    // status
    output logic [msie_pkg::M_TUSER_W-1:0]   o_m_axis_tuser
);
    import msie_pkg::*;

    localparam int AW = $clog2(DATA_WORDS);

    // input fields
    logic [FUNC_W-1:0]  in_func;
    logic [RIDX_W-1:0]  in_first;
    logic [RIDX_W-1:0]  in_second;
    logic [RIDX_W-1:0]  in_third;
    logic               in_use_imm;
    logic [XLEN-1:0]    in_imm;
    logic [PC_W-1:0]    in_target;
    logic [MADDR_W-1:0] in_maddr_raw;
    logic               in_acc;
    logic               in_use_first;
    logic [22:0]        am;
    logic [32:0]        tg0;
    logic [AW-1:0]      in_maddr;

    // execute stage
    logic               r_s1_valid;
    logic [FUNC_W-1:0]  r_s1_func;
    logic [RIDX_W-1:0]  r_s1_rd;
    logic               r_s1_use_imm;
    logic [XLEN-1:0]    r_s1_imm;
    logic [PC_W-1:0]    r_s1_tgt;
    logic [AW-1:0]      r_s1_maddr;
    logic               r_s1_fwd0;
    logic [XLEN-1:0]    r_s1_fwd0_d;
    logic               r_s1_fwd1;
    logic [XLEN-1:0]    r_s1_fwd1_d;
    logic               r_s1_dfwd;
    logic [XLEN-1:0]    r_s1_dfwd_d;
    logic [PC_W-1:0]    r_pc;

    logic               s1_adv;
    logic [XLEN-1:0]    rf_data0;
    logic [XLEN-1:0]    rf_data1;
    logic [XLEN-1:0]    dm_data;
    logic               clr_done;
    logic [XLEN-1:0]    op_a;
    logic [XLEN-1:0]    op_p1;
    logic [XLEN-1:0]    mem_q;
    logic [XLEN-1:0]    mul_lo;
    logic [XLEN-1:0]    cmp_other;
    logic [PC_W:0]      pc_p1;
    logic [PC_W-1:0]    pc_seq;
    logic [32:0]        tg1;
    logic [PC_W-1:0]    tgt_red;
    logic [PC_W-1:0]    n_pc;
    logic               n_wr;
    logic [RIDX_W-1:0]  n_wreg;
    logic [XLEN-1:0]    n_wval;
    logic               n_status;
    logic               n_st;

    t_rf_rd             rf_rd;
    t_rf_wr             rf_wr;

    // output register
    logic               r_out_valid;
    logic [PC_W-1:0]    r_out_pc;
    logic               r_out_wr;
    logic [RIDX_W-1:0]  r_out_wreg;
    logic [XLEN-1:0]    r_out_wval;
    logic               r_out_status;

    assign in_func      = i_s_axis_tuser[3:0];
    assign in_first     = i_s_axis_tdata[4:0];
    assign in_second    = i_s_axis_tdata[9:5];
    assign in_third     = i_s_axis_tdata[14:10];
    assign in_use_imm   = i_s_axis_tdata[15];
    assign in_imm       = i_s_axis_tdata[47:16];
    assign in_target    = i_s_axis_tdata[67:48];
    assign in_maddr_raw = i_s_axis_tdata[77:68];

    assign in_acc       = i_s_axis_tvalid && o_s_axis_tready;
    assign in_use_first = in_func inside {FN_BEQ, FN_BNE, FN_SW};

    // word address modulo DATA_WORDS by restoring subtraction
    always_comb begin
        am = {13'd0, in_maddr_raw};
        for (int k = 6; k >= 0; k--) begin
            if (am >= (23'(DATA_WORDS) << k)) begin
                am = am - (23'(DATA_WORDS) << k);
            end
        end
    end
    assign in_maddr = am[AW-1:0];

    // target modulo PROGRAM_SIZE, upper steps here, lower steps in execute
    always_comb begin
        tg0 = {13'd0, in_target};
        for (int k = 12; k >= 6; k--) begin
            if (tg0 >= (33'(PROGRAM_SIZE) << k)) begin
                tg0 = tg0 - (33'(PROGRAM_SIZE) << k);
            end
        end
    end

    assign s1_adv          = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = clr_done && (!r_s1_valid || s1_adv);

    assign rf_rd.en    = in_acc;
    assign rf_rd.addr0 = in_second;
    assign rf_rd.addr1 = in_use_first ? in_first : in_third;

    msie_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rf_rd),
        .i_wr    (rf_wr),
        .o_data0 (rf_data0),
        .o_data1 (rf_data1)
    );

    msie_dmem #(
        .DATA_WORDS (DATA_WORDS)
    ) u_dmem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_acc),
        .i_rd_addr  (in_maddr),
        .i_wr_en    (s1_adv && (r_s1_func == FN_SW)),
        .i_wr_addr  (r_s1_maddr),
        .i_wr_data  (op_p1),
        .o_rd_data  (dm_data),
        .o_clr_done (clr_done)
    );

    // capture stage: payload, plus forwarding from the write leaving execute
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_func    <= in_func;
            r_s1_rd      <= in_first;
            r_s1_use_imm <= in_use_imm;
            r_s1_imm     <= in_imm;
            r_s1_tgt     <= tg0[PC_W-1:0];
            r_s1_maddr   <= in_maddr;
            r_s1_fwd0    <= rf_wr.en && (rf_wr.addr == rf_rd.addr0);
            r_s1_fwd0_d  <= rf_wr.data;
            r_s1_fwd1    <= rf_wr.en && (rf_wr.addr == rf_rd.addr1);
            r_s1_fwd1_d  <= rf_wr.data;
            r_s1_dfwd    <= s1_adv && (r_s1_func == FN_SW) && (r_s1_maddr == in_maddr);
            r_s1_dfwd_d  <= op_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    assign op_a   = r_s1_fwd0 ? r_s1_fwd0_d : rf_data0;
    assign op_p1  = r_s1_fwd1 ? r_s1_fwd1_d : rf_data1;
    assign mem_q  = r_s1_dfwd ? r_s1_dfwd_d : dm_data;
    assign mul_lo = op_a * op_p1;

    always_comb begin
        tg1 = {13'd0, r_s1_tgt};
        for (int k = 5; k >= 0; k--) begin
            if (tg1 >= (33'(PROGRAM_SIZE) << k)) begin
                tg1 = tg1 - (33'(PROGRAM_SIZE) << k);
            end
        end
    end
    assign tgt_red = tg1[PC_W-1:0];

    assign pc_p1  = {1'b0, r_pc} + 1'b1;
    assign pc_seq = (pc_p1 == (PC_W+1)'(PROGRAM_SIZE)) ? '0 : pc_p1[PC_W-1:0];

    assign cmp_other = r_s1_use_imm ? r_s1_imm : op_a;

    always_comb begin
        n_pc   = pc_seq;
        n_wr   = 1'b0;
        n_wval = '0;
        n_st   = ST_OK;
        case (r_s1_func)
            FN_ADD: begin
                n_wr   = 1'b1;
                n_wval = op_a + op_p1;
            end
            FN_SUB: begin
                n_wr   = 1'b1;
                n_wval = op_a - op_p1;
            end
            FN_MUL: begin
                n_wr   = 1'b1;
                n_wval = mul_lo;
            end
            FN_SLT: begin
                n_wr   = 1'b1;
                n_wval = {{(XLEN-1){1'b0}}, ($signed(op_a) < $signed(op_p1))};
            end
            FN_ADDI: begin
                n_wr   = 1'b1;
                n_wval = op_a + r_s1_imm;
            end
            FN_BEQ: begin
                if (op_p1 == cmp_other) begin
                    n_pc = tgt_red;
                end
            end
            FN_BNE: begin
                if (op_p1 != cmp_other) begin
                    n_pc = tgt_red;
                end
            end
            FN_J: begin
                n_pc = tgt_red;
            end
            FN_LW: begin
                n_wr   = 1'b1;
                n_wval = mem_q;
            end
            FN_SW: begin
                n_wr = 1'b0;
            end
            default: begin
                n_st = ST_UNKNOWN;
            end
        endcase
        // register zero swallows writes
        if (r_s1_rd == '0) begin
            n_wr = 1'b0;
        end
        if (!n_wr) begin
            n_wval = '0;
        end
        n_wreg   = n_wr ? r_s1_rd : '0;
        n_status = n_st;
    end

    assign rf_wr.en   = s1_adv && n_wr;
    assign rf_wr.addr = r_s1_rd;
    assign rf_wr.data = n_wval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else if (s1_adv) begin
            r_pc <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_pc     <= n_pc;
            r_out_wr     <= n_wr;
            r_out_wreg   <= n_wreg;
            r_out_wval   <= n_wval;
            r_out_status <= n_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_wval, r_out_wreg, r_out_wr, r_out_pc};
    assign o_m_axis_tuser  = r_out_status;

endmodule

// File: rtl/msie_checker.sv
// ---------------------------------------------------------------------------
// msie_checker
// port-level checks on the result channel of the instruction executor
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mips_subset_instruction_execute_assert.svh"

module msie_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    input  logic [msie_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    input  logic [msie_pkg::M_TUSER_W-1:0]   o_m_axis_tuser
);

    // stalled result beat keeps its payload
    `MSIE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "result beat changed while stalled")

    // a reported write never targets register zero
    `MSIE_ASSERT_NOW(a_wr_nonzero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[20], o_m_axis_tdata[25:21] != 5'd0, "write reported to register zero")

    // no write means index, value and pad all zero
    `MSIE_ASSERT_NOW(a_nowr_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tdata[20], o_m_axis_tdata[63:21] == 43'd0, "nonzero write fields without a write")

    // an unknown operation writes nothing
    `MSIE_ASSERT_NOW(a_unknown_nowr, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0], !o_m_axis_tdata[20], "unknown operation reported a write")

endmodule

bind mips_subset_instruction_execute msie_checker u_msie_checker (.*);

// File: tb/mips_subset_instruction_execute_checker.sv
// ---------------------------------------------------------------------------
// mips_subset_instruction_execute_checker
// watches both stream channels, runs every taken instruction through its own
// copy of the register file, pc and data memory, and compares each result
// beat with the oldest prediction
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mips_subset_instruction_execute_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    input  logic                            i_s_axis_tready,
    // first_reg, second_reg, third_reg, use_immediate, immediate,
    // target_pc, mem_addr, zero pad
    input  logic [msie_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // func
    input  logic [msie_pkg::S_TUSER_W-1:0]  i_s_axis_tuser,
    input  logic                            i_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // next_pc, reg_written, written_reg, written_value, zero pad
    input  logic [msie_pkg::M_TDATA_W-1:0]  i_m_axis_tdata,
    // status
    input  logic [msie_pkg::M_TUSER_W-1:0]  i_m_axis_tuser,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_result_count
);
    import msie_pkg::*;

    localparam int DATA_WORDS = 1 << MADDR_W;
    localparam int MAX_REPORTS = 10;

    // instruction beat, msb first
    typedef struct packed {
        logic [1:0]         pad;
        logic [MADDR_W-1:0] mem_addr;
        logic [PC_W-1:0]    target_pc;
        logic [XLEN-1:0]    immediate;
        logic               use_imm;
        logic [RIDX_W-1:0]  third_reg;
        logic [RIDX_W-1:0]  second_reg;
        logic [RIDX_W-1:0]  first_reg;
    } t_instr_beat;

    typedef struct packed {
        logic [PC_W-1:0]   next_pc;
        logic              reg_written;
        logic [RIDX_W-1:0] written_reg;
        logic [XLEN-1:0]   written_value;
        logic              status;
    } t_exec_result;

    logic [XLEN-1:0] gpr [NREGS];
    logic [XLEN-1:0] dmem [DATA_WORDS];
    logic [PC_W-1:0] model_pc;

    t_exec_result expected_results [$];
    int mismatches;
    int results_seen;

    function automatic logic [XLEN-1:0] gpr_read(input logic [RIDX_W-1:0] idx);
        return (idx == '0) ? '0 : gpr[idx];
    endfunction

    function automatic t_exec_result execute_instruction(input t_instr_beat b,
                                                        input logic [FUNC_W-1:0] fn);
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] c;
        logic [XLEN-1:0] first_val;
        logic [XLEN-1:0] other;
        logic [XLEN-1:0] val;
        logic [PC_W-1:0] next;
        logic            wr;
        logic            st;
        t_exec_result    r;
        a         = gpr_read(b.second_reg);
        c         = gpr_read(b.third_reg);
        first_val = gpr_read(b.first_reg);
        // 20-bit pc wraps to zero on its own
        next      = model_pc + 1'b1;
        wr        = 1'b0;
        val       = '0;
        st        = ST_OK;
        case (fn)
            FN_ADD:  begin wr = 1'b1; val = a + c; end
            FN_SUB:  begin wr = 1'b1; val = a - c; end
            FN_MUL:  begin wr = 1'b1; val = a * c; end
            FN_SLT:  begin wr = 1'b1; val = XLEN'($signed(a) < $signed(c)); end
            FN_ADDI: begin wr = 1'b1; val = a + b.immediate; end
            FN_BEQ, FN_BNE: begin
                other = b.use_imm ? b.immediate : a;
                if ((fn == FN_BEQ) == (first_val == other))
                    next = b.target_pc;
            end
            FN_J:    next = b.target_pc;
            FN_LW:   begin wr = 1'b1; val = dmem[b.mem_addr]; end
            FN_SW:   dmem[b.mem_addr] = first_val;
            default: st = ST_UNKNOWN;
        endcase
        // writes to register zero vanish
        if (wr && b.first_reg == '0)
            wr = 1'b0;
        if (wr)
            gpr[b.first_reg] = val;
        model_pc        = next;
        r.next_pc       = next;
        r.reg_written   = wr;
        r.written_reg   = wr ? b.first_reg : '0;
        r.written_value = wr ? val : '0;
        r.status        = st;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_exec_result got;
        t_exec_result want;
        if (!i_rst_n) begin
            foreach (gpr[i]) gpr[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
            model_pc = '0;
            expected_results.delete();
            mismatches = 0;
            results_seen = 0;
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.next_pc       = i_m_axis_tdata[19:0];
                got.reg_written   = i_m_axis_tdata[20];
                got.written_reg   = i_m_axis_tdata[25:21];
                got.written_value = i_m_axis_tdata[57:26];
                got.status        = i_m_axis_tuser[0];
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result beat with no instruction pending: pc %05h",
                                 $realtime, got.next_pc);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"%0t: result %0d mismatch: expected pc %05h wr %0b ",
                                      "reg %0d val %08h st %0b, got pc %05h wr %0b reg %0d ",
                                      "val %08h st %0b"}, $realtime, results_seen,
                                     want.next_pc, want.reg_written, want.written_reg,
                                     want.written_value, want.status, got.next_pc,
                                     got.reg_written, got.written_reg, got.written_value,
                                     got.status);
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_results.insert(expected_results.size(), execute_instruction(
                    t_instr_beat'(i_s_axis_tdata), i_s_axis_tuser));
        end
        o_fail_count   <= mismatches;
        o_pending      <= expected_results.size();
        o_result_count <= results_seen;
    end

endmodule

// File: tb/mips_subset_instruction_execute_tb.sv
// ---------------------------------------------------------------------------
// mips_subset_instruction_execute_tb
// drives decoded instructions into the executor, directed corner cases first
// and then a random mix, under changing source idle and sink stall pressure;
// the checker predicts and compares every result beat
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mips_subset_instruction_execute_tb;
    import msie_pkg::*;

    localparam logic [FUNC_W-1:0] FN_UNKNOWN_LO = 4'd10;
    localparam logic [FUNC_W-1:0] FN_UNKNOWN_HI = 4'd15;
    localparam int RANDOM_PER_PHASE = 481;
    localparam int WATCHDOG_LIMIT   = 4096;
    localparam int DRAIN_CYCLES     = 8;

    typedef struct {
        logic [FUNC_W-1:0]  fn;
        logic [RIDX_W-1:0]  rd;
        logic [RIDX_W-1:0]  rs;
        logic [RIDX_W-1:0]  rt;
        logic               use_imm;
        logic [XLEN-1:0]    imm;
        logic [PC_W-1:0]    target;
        logic [MADDR_W-1:0] addr;
    } t_instr;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;

    int fail_count;
    int pending;
    int result_count;
    int src_idle_pct;
    int sink_stall_pct;
    int sent;
    int unknown_sent;
    int quiet_cycles;

    mips_subset_instruction_execute DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    mips_subset_instruction_execute_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_result_count  (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result sink: random backpressure at the current stall rate
    always @(negedge i_clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    // nothing accepted on either side for too long means a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("mips_subset_instruction_execute verification failed");
                $finish;
            end
        end
    end

    function automatic t_instr mk(input logic [FUNC_W-1:0] fn, input int rd, input int rs,
                                  input int rt, input int use_imm, input logic [XLEN-1:0] imm,
                                  input int target, input int addr);
        t_instr ins;
        ins.fn      = fn;
        ins.rd      = RIDX_W'(rd);
        ins.rs      = RIDX_W'(rs);
        ins.rt      = RIDX_W'(rt);
        ins.use_imm = 1'(use_imm);
        ins.imm     = imm;
        ins.target  = PC_W'(target);
        ins.addr    = MADDR_W'(addr);
        return ins;
    endfunction

    // mostly a handful of low registers so results feed each other
    function automatic logic [RIDX_W-1:0] pick_reg();
        return RIDX_W'(($urandom_range(99) < 65) ? $urandom_range(7) : $urandom_range(31));
    endfunction

    function automatic t_instr random_instr();
        t_instr ins;
        int unsigned sel;
        ins.fn      = FUNC_W'(($urandom_range(99) < 5)
                              ? $urandom_range(FN_UNKNOWN_HI, FN_UNKNOWN_LO)
                              : $urandom_range(FN_SW, FN_ADD));
        ins.rd      = pick_reg();
        ins.rs      = pick_reg();
        ins.rt      = pick_reg();
        ins.use_imm = 1'($urandom_range(1));
        sel = $urandom_range(9);
        if (sel < 4)
            ins.imm = XLEN'($urandom_range(3));
        else if (sel == 4)
            ins.imm = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
        else if (sel == 5)
            ins.imm = 32'hffff_ffff;
        else
            ins.imm = $urandom;
        sel = $urandom_range(9);
        ins.target = (sel == 0) ? '0 : (sel == 1) ? '1 : PC_W'($urandom);
        sel = $urandom_range(9);
        ins.addr = MADDR_W'((sel < 6) ? $urandom_range(7)
                                      : (sel == 6) ? 1023 - $urandom_range(3) : $urandom);
        // compare a register with itself now and then so branches get taken
        if ((ins.fn == FN_BEQ || ins.fn == FN_BNE) && $urandom_range(2) == 0)
            ins.rs = ins.rd;
        return ins;
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_instr(input t_instr ins);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ins.fn;
        s_tdata  <= {2'b00, ins.addr, ins.target, ins.imm, ins.use_imm,
                     ins.rt, ins.rs, ins.rd};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent++;
        if (ins.fn > FN_SW)
            unknown_sent++;
        @(negedge i_clk);
    endtask

    // hold off the source until every outstanding result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        t_instr directed [$];
        int phase_idle [4];
        int phase_stall [4];
        i_rst_n        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b1;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        sent           = 0;
        unknown_sent   = 0;
        phase_idle     = '{0, 62, 0, 34};
        phase_stall    = '{0, 0, 62, 34};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // corner cases: wrap arithmetic, register zero, forwarding, pc wrap
        directed = '{
            mk(FN_ADDI, 1, 0, 0, 0, 32'h7fff_ffff, 0, 0),
            mk(FN_ADDI, 2, 0, 0, 0, 32'h8000_0000, 0, 0),
            mk(FN_ADDI, 3, 0, 0, 0, 32'hffff_ffff, 0, 0),
            mk(FN_ADD, 4, 1, 1, 0, 0, 0, 0),
            mk(FN_SUB, 5, 2, 1, 0, 0, 0, 0),
            mk(FN_MUL, 6, 1, 3, 0, 0, 0, 0),
            mk(FN_MUL, 7, 2, 2, 0, 0, 0, 0),
            mk(FN_SLT, 8, 2, 1, 0, 0, 0, 0),
            mk(FN_SLT, 9, 1, 2, 0, 0, 0, 0),
            mk(FN_ADD, 0, 1, 1, 0, 0, 0, 0),
            mk(FN_SUB, 10, 0, 3, 0, 0, 0, 0),
            mk(FN_SW, 1, 0, 0, 0, 0, 0, 1023),
            mk(FN_SW, 2, 0, 0, 0, 0, 0, 0),
            mk(FN_LW, 11, 0, 0, 0, 0, 0, 1023),
            mk(FN_LW, 12, 0, 0, 0, 0, 0, 0),
            mk(FN_LW, 0, 0, 0, 0, 0, 0, 1023),
            mk(FN_LW, 13, 0, 0, 0, 0, 0, 512),
            mk(FN_BEQ, 1, 1, 0, 0, 0, 20'hfffff, 0),
            mk(FN_ADD, 14, 1, 3, 0, 0, 0, 0),
            mk(FN_BEQ, 3, 0, 0, 1, 32'hffff_ffff, 20'h12345, 0),
            mk(FN_BNE, 1, 2, 0, 0, 0, 20'h00000, 0),
            mk(FN_BNE, 0, 0, 0, 1, 0, 20'h0004d, 0),
            mk(FN_J, 31, 31, 31, 1, 32'hffff_ffff, 20'h00abc, 1023),
            mk(FN_UNKNOWN_LO, 5, 6, 7, 1, 32'h1234_5678, 20'h55555, 341),
            mk(FN_UNKNOWN_HI, 31, 31, 31, 1, 32'hffff_ffff, 20'hfffff, 1023),
            mk(FN_SW, 0, 0, 0, 0, 0, 0, 5)
        };
        foreach (directed[i])
            send_instr(directed[i]);
        drain_results();

        for (int p = 0; p < 4; p++) begin
            src_idle_pct   = phase_idle[p];
            sink_stall_pct = phase_stall[p];
            repeat (RANDOM_PER_PHASE)
                send_instr(random_instr());
            drain_results();
        end
        src_idle_pct   = 0;
        sink_stall_pct = 0;

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d instructions (%0d unknown ops): directed corners, then random",
                 sent, unknown_sent);
        $display("mixes under no, source, sink and combined pressure; %0d results compared",
                 result_count);
        if (fail_count == 0 && pending == 0) begin
            $display("mips_subset_instruction_execute verification clean");
        end else begin
            $display("mips_subset_instruction_execute verification failed");
        end
        $finish;
    end

endmodule
